// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, constants and pipeline sideband types for the Schlick
// Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int VEC_W  = 16;   // Q2.14 vector component
  localparam int IDX_W  = 15;   // Q2.13 refractive index
  localparam int COS_W  = 18;   // signed Q16 cosine, -1.0 .. 1.0
  localparam int REFL_W = 17;   // Q1.16 reflectance

  localparam logic [REFL_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [32:0]       ONE_Q32 = 33'h1_0000_0000;

  // Divider lanes: lane a gives sin^2 of the transmitted angle, lane b gives r0
  localparam int Q_W     = 33;
  localparam int NUM_A_W = 62;
  localparam int DEN_A_W = 30;
  localparam int NUM_B_W = 47;
  localparam int DEN_B_W = 33;

  localparam int ROOT_STEPS = 17;
  localparam int POW_STEPS  = 4;
  localparam int P_W        = 22;  // (1 - cos)^k in Q16, up to 2^21

  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = Q_W;
  localparam int SQRT_LAT  = ROOT_STEPS + 1;
  localparam int TAIL_LAT  = POW_STEPS + 3;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + SQRT_LAT + TAIL_LAT;

  typedef struct packed {
    logic                    tir;
    logic                    gt;
    logic signed [COS_W-1:0] c;
  } sfr_side_t;

  typedef struct packed {
    sfr_side_t base;
    logic      den_a_zero;
    logic      den_b_zero;
  } sfr_div_side_t;

endpackage

// ===== rtl/sfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_front
// Dot product, cosine rounding and clamp, index squares, numerator of
// sin^2 and the total internal reflection test, over seven stages.
// ----------------------------------------------------------------------------
module sfr_front
  import sfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] eye_x,
  input  logic signed [VEC_W-1:0] eye_y,
  input  logic signed [VEC_W-1:0] eye_z,
  input  logic signed [VEC_W-1:0] normal_x,
  input  logic signed [VEC_W-1:0] normal_y,
  input  logic signed [VEC_W-1:0] normal_z,
  input  logic        [IDX_W-1:0] index_incident,
  input  logic        [IDX_W-1:0] index_transmitted,
  output logic                    out_valid,
  output sfr_div_side_t           out_side,
  output logic [NUM_A_W-1:0]      num_a,
  output logic [DEN_A_W-1:0]      den_a,
  output logic [NUM_B_W-1:0]      num_b,
  output logic [DEN_B_W-1:0]      den_b
);

  logic [FRONT_LAT-1:1] v;

  // stage 1
  logic signed [31:0] p_x, p_y, p_z;
  logic [IDX_W-1:0]   n1_1, n2_1;
  // stage 2
  logic signed [COS_W-1:0] c2, c_next;
  logic                    gt2;
  logic [IDX_W-1:0]        n1_2, n2_2, d2;
  logic [IDX_W:0]          s2;
  logic signed [33:0]      dot, dot_sh;
  // stage 3
  logic signed [COS_W-1:0] c3;
  logic                    gt3;
  logic signed [35:0]      csq;
  logic [32:0]             cc3;
  logic [29:0]             n1sq3, n2sq3, dsq3;
  logic [31:0]             ssq3;
  // stage 4
  logic signed [COS_W-1:0] c4;
  logic                    gt4;
  logic [32:0]             om4;
  logic [29:0]             n1sq4, n2sq4;
  logic [31:0]             ssq4;
  logic [NUM_B_W-1:0]      rn4;
  // stage 5
  logic signed [COS_W-1:0] c5;
  logic                    gt5, hi5;
  logic [NUM_A_W-1:0]      pp5;
  logic [29:0]             n1sq5, n2sq5;
  logic [31:0]             ssq5;
  logic [NUM_B_W-1:0]      rn5;
  // stage 6
  logic signed [COS_W-1:0] c6;
  logic                    gt6;
  logic [NUM_A_W-1:0]      num6;
  logic [29:0]             n2sq6;
  logic [31:0]             ssq6;
  logic [NUM_B_W-1:0]      rn6;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      v         <= {v[FRONT_LAT-2:1], in_valid};
      out_valid <= v[FRONT_LAT-1];
    end
  end

  // round the dot product to Q16 and clamp to -1.0 .. 1.0
  assign dot    = 34'(p_x) + 34'(p_y) + 34'(p_z) + 34'sd2048;
  assign dot_sh = dot >>> 12;
  always_comb begin
    if (dot_sh > 34'sd65536) begin
      c_next = 18'sd65536;
    end else if (dot_sh < -34'sd65536) begin
      c_next = -18'sd65536;
    end else begin
      c_next = dot_sh[COS_W-1:0];
    end
  end

  assign csq = c2 * c2;

  always_ff @(posedge clk) begin
    // stage 1: component products
    p_x  <= eye_x * normal_x;
    p_y  <= eye_y * normal_y;
    p_z  <= eye_z * normal_z;
    n1_1 <= index_incident;
    n2_1 <= index_transmitted;
    // stage 2: cosine, index difference and sum
    c2   <= c_next;
    gt2  <= n1_1 > n2_1;
    d2   <= (n1_1 > n2_1) ? n1_1 - n2_1 : n2_1 - n1_1;
    s2   <= {1'b0, n1_1} + {1'b0, n2_1};
    n1_2 <= n1_1;
    n2_2 <= n2_1;
    // stage 3: squares
    c3    <= c2;
    gt3   <= gt2;
    cc3   <= csq[32:0];
    n1sq3 <= {15'b0, n1_2} * {15'b0, n1_2};
    n2sq3 <= {15'b0, n2_2} * {15'b0, n2_2};
    dsq3  <= {15'b0, d2} * {15'b0, d2};
    ssq3  <= {16'b0, s2} * {16'b0, s2};
    // stage 4: 1 - cos^2 and the r0 numerator with its rounding term
    c4    <= c3;
    gt4   <= gt3;
    om4   <= ONE_Q32 - cc3;
    n1sq4 <= n1sq3;
    n2sq4 <= n2sq3;
    ssq4  <= ssq3;
    rn4   <= {1'b0, dsq3, 16'b0} + {16'b0, ssq3[31:1]};
    // stage 5: low partial product of n1^2 * (1 - cos^2)
    c5    <= c4;
    gt5   <= gt4;
    pp5   <= {32'b0, n1sq4} * {30'b0, om4[31:0]};
    hi5   <= om4[32];
    n1sq5 <= n1sq4;
    n2sq5 <= n2sq4;
    ssq5  <= ssq4;
    rn5   <= rn4;
    // stage 6: add the high partial product
    c6    <= c5;
    gt6   <= gt5;
    num6  <= pp5 + (hi5 ? {n1sq5, 32'b0} : '0);
    n2sq6 <= n2sq5;
    ssq6  <= ssq5;
    rn6   <= rn5;
    // stage 7: total internal reflection test, hand off to the dividers
    out_side.base.tir  <= gt6 && (num6 > {n2sq6, 32'b0});
    out_side.base.gt   <= gt6;
    out_side.base.c    <= c6;
    out_side.den_a_zero <= n2sq6 == '0;
    out_side.den_b_zero <= ssq6 == '0;
    num_a <= num6;
    den_a <= n2sq6;
    num_b <= rn6;
    den_b <= {1'b0, ssq6};
  end

endmodule

// ===== rtl/sfr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_div
// Two-lane pipelined restoring divider, one quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module sfr_div
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  sfr_div_side_t      in_side,
  input  logic [NUM_A_W-1:0] num_a,
  input  logic [DEN_A_W-1:0] den_a,
  input  logic [NUM_B_W-1:0] num_b,
  input  logic [DEN_B_W-1:0] den_b,
  output logic               out_valid,
  output sfr_div_side_t      out_side,
  output logic [Q_W-1:0]     q_a,
  output logic [Q_W-1:0]     q_b
);

  localparam int RA_W = DEN_A_W + 1;
  localparam int RB_W = DEN_B_W + 1;

  logic                v    [1:Q_W];
  sfr_div_side_t       side [1:Q_W];
  logic [RA_W-1:0]     rem_a  [1:Q_W];
  logic [Q_W-1:0]      work_a [1:Q_W];
  logic [DEN_A_W-1:0]  dv_a   [1:Q_W];
  logic [RB_W-1:0]     rem_b  [1:Q_W];
  logic [Q_W-1:0]      work_b [1:Q_W];
  logic [DEN_B_W-1:0]  dv_b   [1:Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic                v_src;
    sfr_div_side_t       s_src;
    logic [RA_W-1:0]     ra_src, sha;
    logic [Q_W-1:0]      wa_src, wb_src;
    logic [DEN_A_W-1:0]  da_src;
    logic [RB_W-1:0]     rb_src, shb;
    logic [DEN_B_W-1:0]  db_src;
    logic                ge_a, ge_b;

    // pick the stage source: ports for the first, registers after
    if (k == 0) begin : g_first
      assign v_src  = in_valid;
      assign s_src  = in_side;
      assign ra_src = RA_W'(num_a[NUM_A_W-1:Q_W]);
      assign wa_src = num_a[Q_W-1:0];
      assign da_src = den_a;
      assign rb_src = RB_W'(num_b[NUM_B_W-1:Q_W]);
      assign wb_src = num_b[Q_W-1:0];
      assign db_src = den_b;
    end else begin : g_rest
      assign v_src  = v[k];
      assign s_src  = side[k];
      assign ra_src = rem_a[k];
      assign wa_src = work_a[k];
      assign da_src = dv_a[k];
      assign rb_src = rem_b[k];
      assign wb_src = work_b[k];
      assign db_src = dv_b[k];
    end

    // shift in the next numerator bit and try the subtraction
    assign sha  = {ra_src[RA_W-2:0], wa_src[Q_W-1]};
    assign shb  = {rb_src[RB_W-2:0], wb_src[Q_W-1]};
    assign ge_a = sha >= {1'b0, da_src};
    assign ge_b = shb >= {1'b0, db_src};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      side[k+1]   <= s_src;
      rem_a[k+1]  <= ge_a ? sha - {1'b0, da_src} : sha;
      work_a[k+1] <= {wa_src[Q_W-2:0], ge_a};
      dv_a[k+1]   <= da_src;
      rem_b[k+1]  <= ge_b ? shb - {1'b0, db_src} : shb;
      work_b[k+1] <= {wb_src[Q_W-2:0], ge_b};
      dv_b[k+1]   <= db_src;
    end
  end

  assign out_valid = v[Q_W];
  assign out_side  = side[Q_W];
  assign q_a       = work_a[Q_W];
  assign q_b       = work_b[Q_W];

endmodule

// ===== rtl/sfr_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_sqrt
// Forms 1 - sin^2 and r0 from the quotients, then takes the integer square
// root over one bit-pair stage per result bit.
// ----------------------------------------------------------------------------
module sfr_sqrt
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sfr_div_side_t     in_side,
  input  logic [Q_W-1:0]    q_a,
  input  logic [Q_W-1:0]    q_b,
  output logic              out_valid,
  output sfr_side_t         out_side,
  output logic [REFL_W-1:0] r0,
  output logic [REFL_W-1:0] root
);

  logic              v     [0:ROOT_STEPS];
  sfr_side_t         side  [0:ROOT_STEPS];
  logic [REFL_W-1:0] r0_s  [0:ROOT_STEPS];
  logic [32:0]       val   [0:ROOT_STEPS];
  logic [33:0]       rt    [0:ROOT_STEPS];
  logic [32:0]       sin2t;

  // clamp sin^2 to one; a zero divisor means sin^2 is zero
  always_comb begin
    if (in_side.den_a_zero) begin
      sin2t = '0;
    end else if (q_a > ONE_Q32) begin
      sin2t = ONE_Q32;
    end else begin
      sin2t = q_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  // prepare the radicand and finish r0
  always_ff @(posedge clk) begin
    side[0] <= in_side.base;
    val[0]  <= ONE_Q32 - sin2t;
    rt[0]   <= '0;
    if (in_side.den_b_zero) begin
      r0_s[0] <= '0;
    end else if (q_b > 33'(ONE_Q16)) begin
      r0_s[0] <= ONE_Q16;
    end else begin
      r0_s[0] <= q_b[REFL_W-1:0];
    end
  end

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [33:0] BIT = 34'd1 << (32 - 2 * k);
    logic [33:0] trial;
    logic        ge;

    assign trial = rt[k] + BIT;
    assign ge    = {1'b0, val[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      side[k+1] <= side[k];
      r0_s[k+1] <= r0_s[k];
      val[k+1]  <= ge ? val[k] - trial[32:0] : val[k];
      rt[k+1]   <= ge ? (rt[k] >> 1) + BIT : rt[k] >> 1;
    end
  end

  assign out_valid = v[ROOT_STEPS];
  assign out_side  = side[ROOT_STEPS];
  assign r0        = r0_s[ROOT_STEPS];
  assign root      = rt[ROOT_STEPS][REFL_W-1:0];

endmodule

// ===== rtl/sfr_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_tail
// Selects the cosine, raises (1 - cos) to the fifth power over four
// multiply stages, blends with r0 and saturates.
// ----------------------------------------------------------------------------
module sfr_tail
  import sfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sfr_side_t         in_side,
  input  logic [REFL_W-1:0] r0,
  input  logic [REFL_W-1:0] root,
  output logic              done,
  output logic [REFL_W-1:0] reflectance,
  output logic              total_internal
);

  logic                    v    [0:POW_STEPS];
  logic                    tir  [0:POW_STEPS];
  logic [REFL_W-1:0]       r0_s [0:POW_STEPS];
  logic [COS_W-1:0]        t    [0:POW_STEPS];
  logic [P_W-1:0]          p    [0:POW_STEPS];

  logic signed [COS_W-1:0] c_sel;
  logic signed [COS_W:0]   t_full;
  logic                    vb, tirb;
  logic [REFL_W-1:0]       r0b, omr;
  logic [22:0]             bl;
  logic [38:0]             bm;
  logic [23:0]             sum;

  // take the refracted cosine when n1 > n2
  assign c_sel  = in_side.gt ? signed'({1'b0, root}) : in_side.c;
  assign t_full = 19'sd65536 - 19'(c_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tir[0]  <= in_side.tir;
    r0_s[0] <= r0;
    t[0]    <= t_full[COS_W-1:0];
    p[0]    <= P_W'(t_full[COS_W-1:0]);
  end

  // multiply by t, round half up to Q16
  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
    logic [39:0] m;
    assign m = 40'(p[k]) * 40'(t[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      tir[k+1]  <= tir[k];
      r0_s[k+1] <= r0_s[k];
      t[k+1]    <= t[k];
      p[k+1]    <= P_W'((m + 40'd32768) >> 16);
    end
  end

  // blend (1 - r0) * p
  assign omr = ONE_Q16 - r0_s[POW_STEPS];
  assign bm  = 39'(omr) * 39'(p[POW_STEPS]);
  assign sum = 24'(r0b) + 24'(bl);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb   <= 1'b0;
      done <= 1'b0;
    end else begin
      vb   <= v[POW_STEPS];
      done <= vb;
    end
  end

  // add r0, saturate, force one on total internal reflection
  always_ff @(posedge clk) begin
    bl             <= 23'((bm + 39'd32768) >> 16);
    r0b            <= r0_s[POW_STEPS];
    tirb           <= tir[POW_STEPS];
    total_internal <= tirb;
    if (tirb || sum > 24'(ONE_Q16)) begin
      reflectance <= ONE_Q16;
    end else begin
      reflectance <= sum[REFL_W-1:0];
    end
  end

endmodule

// ===== rtl/schlick_fresnel_reflectance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schlick_fresnel_reflectance_unit
// Schlick approximation of Fresnel reflectance with total internal
// reflection detection, fully pipelined.
// ----------------------------------------------------------------------------
// A request is taken on every clock with start high; busy is always low.
// Each request produces one result, shown for one cycle with done high,
// after it passes through 7 front stages (dot product, squares, sin^2
// numerator), 33 stages of the restoring divider (one quotient bit each),
// 18 stages of the square root and 7 tail stages (four power multiplies,
// blend, saturation). Results cannot be held off, so no stall path
// exists and throughput is one request per cycle.
// ----------------------------------------------------------------------------
module schlick_fresnel_reflectance_unit
  import sfr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VEC_W-1:0] eye_x,
  input  logic signed [VEC_W-1:0] eye_y,
  input  logic signed [VEC_W-1:0] eye_z,
  input  logic signed [VEC_W-1:0] normal_x,
  input  logic signed [VEC_W-1:0] normal_y,
  input  logic signed [VEC_W-1:0] normal_z,
  input  logic        [IDX_W-1:0] index_incident,
  input  logic        [IDX_W-1:0] index_transmitted,
  output logic                    done,
  output logic [REFL_W-1:0]       reflectance,
  output logic                    total_internal
);

  logic               f_valid, d_valid, s_valid;
  sfr_div_side_t      f_side, d_side;
  sfr_side_t          s_side;
  logic [NUM_A_W-1:0] num_a;
  logic [DEN_A_W-1:0] den_a;
  logic [NUM_B_W-1:0] num_b;
  logic [DEN_B_W-1:0] den_b;
  logic [Q_W-1:0]     q_a, q_b;
  logic [REFL_W-1:0]  r0, root;

  // accept a request every cycle
  assign busy = 1'b0;

  sfr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (start && !busy),
    .eye_x            (eye_x),
    .eye_y            (eye_y),
    .eye_z            (eye_z),
    .normal_x         (normal_x),
    .normal_y         (normal_y),
    .normal_z         (normal_z),
    .index_incident   (index_incident),
    .index_transmitted(index_transmitted),
    .out_valid        (f_valid),
    .out_side         (f_side),
    .num_a            (num_a),
    .den_a            (den_a),
    .num_b            (num_b),
    .den_b            (den_b)
  );

  sfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_side  (f_side),
    .num_a    (num_a),
    .den_a    (den_a),
    .num_b    (num_b),
    .den_b    (den_b),
    .out_valid(d_valid),
    .out_side (d_side),
    .q_a      (q_a),
    .q_b      (q_b)
  );

  sfr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_side  (d_side),
    .q_a      (q_a),
    .q_b      (q_b),
    .out_valid(s_valid),
    .out_side (s_side),
    .r0       (r0),
    .root     (root)
  );

  sfr_tail u_tail (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_valid),
    .in_side       (s_side),
    .r0            (r0),
    .root          (root),
    .done          (done),
    .reflectance   (reflectance),
    .total_internal(total_internal)
  );

endmodule

// ===== rtl/sfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of latency, range and the total internal reflection
// flag, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic signed [VEC_W-1:0] eye_x,
  input logic signed [VEC_W-1:0] eye_y,
  input logic signed [VEC_W-1:0] eye_z,
  input logic signed [VEC_W-1:0] normal_x,
  input logic signed [VEC_W-1:0] normal_y,
  input logic signed [VEC_W-1:0] normal_z,
  input logic        [IDX_W-1:0] index_incident,
  input logic        [IDX_W-1:0] index_transmitted,
  input logic                    done,
  input logic [REFL_W-1:0]       reflectance,
  input logic                    total_internal
);

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching request");

  // reflectance stays within 0 .. 1.0
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> reflectance <= ONE_Q16)
    else $error("reflectance above one");

  // total internal reflection forces one
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    (done && total_internal) |-> reflectance == ONE_Q16)
    else $error("total internal reflection without full reflectance");

  // total internal reflection only when the incident index is larger
  a_tir_idx: assert property (@(posedge clk) disable iff (rst)
    (done && total_internal) |->
      $past(index_incident, TOTAL_LAT) > $past(index_transmitted, TOTAL_LAT))
    else $error("total internal reflection with n1 not above n2");

endmodule

bind schlick_fresnel_reflectance_unit sfr_checker u_sfr_checker (.*);
